// File: design/mm4f_pkg.sv
// mm4f_pkg: shared types and constants for the 4x4 binary32 matrix multiplier.
// Holds the request/result structs, the controller state type and the
// command/status bundles. No dependencies.
`default_nettype none
package mm4f_pkg;

  localparam int DIM   = 4;
  localparam int CELLS = DIM * DIM;
  localparam int IDX_W = $clog2(CELLS);
  localparam int K_W   = $clog2(DIM);
  localparam int FP_W  = 32;

  // request kinds
  localparam logic [1:0] KIND_LEFT    = 2'd0;
  localparam logic [1:0] KIND_RIGHT   = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  localparam logic [FP_W-1:0] FP_ZERO    = 32'h0000_0000;
  localparam logic [FP_W-1:0] FP_DEF_NAN = 32'hFFC0_0000;

  typedef struct packed {
    logic [1:0]      kind;
    logic [IDX_W-1:0] element_index;
    logic [FP_W-1:0] element_value;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    logic [FP_W-1:0] result_value;
    logic            last;
  } out_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_MLZ,
    ST_MRND,
    ST_ALN,
    ST_SUM,
    ST_ALZ,
    ST_ARND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;     // clear counters and accumulator
    logic rd;        // issue matrix reads for current term
    logic mul;       // multiply, load normaliser
    logic lz;        // leading-zero count
    logic rnd_prod;  // round into product register
    logic rnd_acc;   // round into accumulator, advance k
    logic aln;       // align addends
    logic sum;       // add/subtract, load normaliser
    logic emit;      // load output register, advance cell
  } cmd_t;

  typedef struct packed {
    logic k_last;
    logic cell_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// File: design/mm4f_ram.sv
// mm4f_ram: generic simple dual-port RAM, one write port, one registered read.
// Depends on nothing.
`default_nettype none
module mm4f_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/mm4f_ctrl.sv
// mm4f_ctrl: sequencer for the multiply-accumulate walk over all cells.
// Depends on mm4f_pkg for state, command and status types.
`default_nettype none
module mm4f_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [1:0]      in_kind,
  output logic                 in_stall,
  input  wire mm4f_pkg::sts_t  sts,
  output mm4f_pkg::cmd_t       cmd
);

  mm4f_pkg::state_t state_r, state_nxt;
  logic go;

  assign go       = in_valid && (in_kind == mm4f_pkg::KIND_COMPUTE);
  assign in_stall = (state_r != mm4f_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mm4f_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mm4f_pkg::ST_IDLE: if (go) state_nxt = mm4f_pkg::ST_READ;
      mm4f_pkg::ST_READ: state_nxt = mm4f_pkg::ST_MUL;
      mm4f_pkg::ST_MUL:  state_nxt = mm4f_pkg::ST_MLZ;
      mm4f_pkg::ST_MLZ:  state_nxt = mm4f_pkg::ST_MRND;
      mm4f_pkg::ST_MRND: state_nxt = mm4f_pkg::ST_ALN;
      mm4f_pkg::ST_ALN:  state_nxt = mm4f_pkg::ST_SUM;
      mm4f_pkg::ST_SUM:  state_nxt = mm4f_pkg::ST_ALZ;
      mm4f_pkg::ST_ALZ:  state_nxt = mm4f_pkg::ST_ARND;
      mm4f_pkg::ST_ARND: state_nxt = sts.k_last ? mm4f_pkg::ST_EMIT : mm4f_pkg::ST_READ;
      mm4f_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.cell_last ? mm4f_pkg::ST_IDLE : mm4f_pkg::ST_READ;
        end
      end
      default: state_nxt = mm4f_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      mm4f_pkg::ST_IDLE: cmd.start    = go;
      mm4f_pkg::ST_READ: cmd.rd       = 1'b1;
      mm4f_pkg::ST_MUL:  cmd.mul      = 1'b1;
      mm4f_pkg::ST_MLZ:  cmd.lz       = 1'b1;
      mm4f_pkg::ST_MRND: cmd.rnd_prod = 1'b1;
      mm4f_pkg::ST_ALN:  cmd.aln      = 1'b1;
      mm4f_pkg::ST_SUM:  cmd.sum      = 1'b1;
      mm4f_pkg::ST_ALZ:  cmd.lz       = 1'b1;
      mm4f_pkg::ST_ARND: cmd.rnd_acc  = 1'b1;
      mm4f_pkg::ST_EMIT: cmd.emit     = sts.out_free;
      default:           cmd          = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: design/mm4f_dp.sv
// mm4f_dp: matrix stores, binary32 multiply and add with a shared
// normalise/round unit, accumulator and output register.
// Depends on mm4f_pkg and mm4f_ram.
`default_nettype none
module mm4f_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire mm4f_pkg::in_req_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mm4f_pkg::out_res_t      out_data,
  input  wire mm4f_pkg::cmd_t     cmd,
  output mm4f_pkg::sts_t          sts
);

  localparam int IW = mm4f_pkg::IDX_W;
  localparam int KW = mm4f_pkg::K_W;

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  function automatic logic is_nan(input logic [31:0] x);
    return (&x[30:23]) && (|x[22:0]);
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return (&x[30:23]) && !(|x[22:0]);
  endfunction

  // counters
  logic [KW-1:0] k_r;
  logic [IW-1:0] cell_r;
  logic          ld_accept;

  // matrix stores
  logic [31:0] lft_q, rgt_q;
  logic [IW-1:0] lft_ra, rgt_ra;

  assign ld_accept = in_valid && !in_stall;
  assign lft_ra = {cell_r[IW-1:KW], k_r};
  assign rgt_ra = {k_r, cell_r[KW-1:0]};

  mm4f_ram #(.WIDTH(mm4f_pkg::FP_W), .DEPTH(mm4f_pkg::CELLS)) u_left (
    .clk   (clk),
    .we    (ld_accept && (in_data.kind == mm4f_pkg::KIND_LEFT)),
    .waddr (in_data.element_index),
    .wdata (in_data.element_value),
    .raddr (lft_ra),
    .rdata (lft_q)
  );

  mm4f_ram #(.WIDTH(mm4f_pkg::FP_W), .DEPTH(mm4f_pkg::CELLS)) u_right (
    .clk   (clk),
    .we    (ld_accept && (in_data.kind == mm4f_pkg::KIND_RIGHT)),
    .waddr (in_data.element_index),
    .wdata (in_data.element_value),
    .raddr (rgt_ra),
    .rdata (rgt_q)
  );

  // normaliser inputs
  logic [47:0]        nm_r;
  logic signed [10:0] ne_r;
  logic               ns_r;
  logic               nspec_r;
  logic [31:0]        nspv_r;
  logic [5:0]         lz_r;
  logic [31:0]        prod_r, acc_r;

  // ---- multiply ----
  logic [23:0] ma, mb;
  logic [7:0]  ea, eb;
  logic        m_sign, m_spec;
  logic [31:0] m_spv;
  logic [47:0] m_p;
  logic signed [10:0] m_e;

  always_comb begin
    ma     = {|lft_q[30:23], lft_q[22:0]};
    mb     = {|rgt_q[30:23], rgt_q[22:0]};
    ea     = (lft_q[30:23] == 8'd0) ? 8'd1 : lft_q[30:23];
    eb     = (rgt_q[30:23] == 8'd0) ? 8'd1 : rgt_q[30:23];
    m_sign = lft_q[31] ^ rgt_q[31];
    m_p    = ma * mb;
    m_e    = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd126;
    m_spec = 1'b1;
    if (is_nan(lft_q)) begin
      m_spv = lft_q | 32'h0040_0000;
    end else if (is_nan(rgt_q)) begin
      m_spv = rgt_q | 32'h0040_0000;
    end else if ((is_inf(lft_q) && rgt_q[30:0] == 31'd0) ||
                 (is_inf(rgt_q) && lft_q[30:0] == 31'd0)) begin
      m_spv = mm4f_pkg::FP_DEF_NAN;
    end else if (is_inf(lft_q) || is_inf(rgt_q)) begin
      m_spv = {m_sign, 8'hFF, 23'd0};
    end else if (lft_q[30:0] == 31'd0 || rgt_q[30:0] == 31'd0) begin
      m_spv = {m_sign, 31'd0};
    end else begin
      m_spec = 1'b0;
      m_spv  = mm4f_pkg::FP_ZERO;
    end
  end

  // ---- add: align ----
  logic [31:0] big, sml;
  logic [7:0]  a_eb, a_es, a_d, a_dc;
  logic [26:0] a_ms;
  logic [53:0] a_tmp;
  logic        a_spec;
  logic [31:0] a_spv;
  logic [26:0] aa_r, ab_r;
  logic        asub_r, asgn_r, aand_r, aspec_r;
  logic [7:0]  aexp_r;
  logic [31:0] aspv_r;

  always_comb begin
    if (acc_r[30:0] >= prod_r[30:0]) begin
      big = acc_r;
      sml = prod_r;
    end else begin
      big = prod_r;
      sml = acc_r;
    end
    a_eb  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    a_es  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    a_d   = a_eb - a_es;
    a_dc  = (a_d > 8'd27) ? 8'd27 : a_d;
    a_ms  = {|sml[30:23], sml[22:0], 3'd0};
    a_tmp = {a_ms, 27'd0} >> a_dc;
    a_spec = 1'b1;
    if (is_nan(acc_r)) begin
      a_spv = acc_r | 32'h0040_0000;
    end else if (is_nan(prod_r)) begin
      a_spv = prod_r | 32'h0040_0000;
    end else if (is_inf(acc_r) && is_inf(prod_r) && (acc_r[31] != prod_r[31])) begin
      a_spv = mm4f_pkg::FP_DEF_NAN;
    end else if (is_inf(acc_r)) begin
      a_spv = acc_r;
    end else if (is_inf(prod_r)) begin
      a_spv = prod_r;
    end else begin
      a_spec = 1'b0;
      a_spv  = mm4f_pkg::FP_ZERO;
    end
  end

  // ---- add: sum ----
  logic [27:0] s_sum;
  assign s_sum = asub_r ? ({1'b0, aa_r} - {1'b0, ab_r}) : ({1'b0, aa_r} + {1'b0, ab_r});

  // ---- shared normalise and round ----
  logic signed [10:0] rn_e;
  logic [47:0]        rn_m;
  logic [7:0]         rn_ef;
  logic [6:0]         rn_rs;
  logic [95:0]        rn_tmp;
  logic               rn_stk, rn_inc;
  logic [30:0]        rn_pack;
  logic [31:0]        rn_val;

  always_comb begin
    rn_e   = ne_r - $signed({5'd0, lz_r});
    rn_stk = 1'b0;
    rn_rs  = 7'd0;
    rn_tmp = '0;
    if (rn_e >= 11'sd1) begin
      rn_m  = nm_r << lz_r;
      rn_ef = rn_e[7:0];
    end else if (ne_r >= 11'sd1) begin
      rn_m  = nm_r << (ne_r[5:0] - 6'd1);
      rn_ef = 8'd0;
    end else begin
      // subnormal result: shift right, keep sticky
      rn_rs  = (ne_r <= -11'sd47) ? 7'd48 : 7'(11'sd1 - ne_r);
      rn_tmp = {nm_r, 48'd0} >> rn_rs;
      rn_m   = rn_tmp[95:48];
      rn_stk = |rn_tmp[47:0];
      rn_ef  = 8'd0;
    end
    rn_inc  = rn_m[23] && (rn_stk || (|rn_m[22:0]) || rn_m[24]);
    rn_pack = {rn_ef, rn_m[46:24]} + {30'd0, rn_inc};
    if (nspec_r) begin
      rn_val = nspv_r;
    end else if (rn_e >= 11'sd255) begin
      rn_val = {ns_r, 8'hFF, 23'd0};
    end else begin
      rn_val = {ns_r, rn_pack};
    end
  end

  // ---- registers ----
  logic      out_valid_r, out_valid_nxt;
  mm4f_pkg::out_res_t out_data_r;

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      k_r         <= '0;
      cell_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.start) begin
        k_r    <= '0;
        cell_r <= '0;
      end else begin
        if (cmd.rnd_acc) k_r <= k_r + 1'b1;
        if (cmd.emit) cell_r <= cell_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start || cmd.emit) acc_r <= mm4f_pkg::FP_ZERO;
    else if (cmd.rnd_acc) acc_r <= rn_val;
    if (cmd.rnd_prod) prod_r <= rn_val;
    if (cmd.lz) lz_r <= lzc48(nm_r);
    if (cmd.mul) begin
      nm_r    <= m_p;
      ne_r    <= m_e;
      ns_r    <= m_sign;
      nspec_r <= m_spec;
      nspv_r  <= m_spv;
    end else if (cmd.sum) begin
      nm_r    <= {s_sum, 20'd0};
      ne_r    <= $signed({3'd0, aexp_r}) + 11'sd1;
      ns_r    <= asgn_r;
      // exact zero: +0 unless both addends were -0
      nspec_r <= aspec_r || (s_sum == 28'd0);
      nspv_r  <= aspec_r ? aspv_r : {aand_r, 31'd0};
    end
    if (cmd.aln) begin
      aa_r    <= {|big[30:23], big[22:0], 3'd0};
      ab_r    <= a_tmp[53:27] | {26'd0, |a_tmp[26:0]};
      asub_r  <= acc_r[31] ^ prod_r[31];
      asgn_r  <= big[31];
      aand_r  <= acc_r[31] & prod_r[31];
      aexp_r  <= a_eb;
      aspec_r <= a_spec;
      aspv_r  <= a_spv;
    end
    if (cmd.emit) begin
      out_data_r.result_index <= cell_r;
      out_data_r.result_value <= acc_r;
      out_data_r.last         <= sts.cell_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign sts.k_last    = (k_r == KW'(mm4f_pkg::DIM - 1));
  assign sts.cell_last = (cell_r == IW'(mm4f_pkg::CELLS - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  // ---- assertions ----
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while stalled");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.cell_last) |=> (cell_r == '0))
    else $error("cell counter not wrapped after last cell");

  a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (acc_r == mm4f_pkg::FP_ZERO && k_r == '0))
    else $error("accumulator or term counter not cleared");

  a_k_at_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (k_r == '0))
    else $error("cell emitted with terms outstanding");

endmodule
`default_nettype wire

// File: design/matrix_multiply_4x4_float_top.sv
// matrix_multiply_4x4_float_top: 4x4 binary32 matrix multiplier.
// Load requests are accepted whenever the controller is idle. A compute request
// stalls the input until all 16 product elements are emitted; each element takes
// 4 terms x 8 controller steps, plus one emit step. A stalled output register
// delays each later element by the stall.
// Synchronous active-low reset clears control only; matrices undefined until loaded.
`default_nettype none
module matrix_multiply_4x4_float_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mm4f_pkg::in_req_t  in_data,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mm4f_pkg::out_res_t      out_data
);

  mm4f_pkg::cmd_t cmd;
  mm4f_pkg::sts_t sts;

  // Controller: accepts requests only when idle; sequences one cell at a time.
  mm4f_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: stores, arithmetic, output register (lets the next request in
  // while the final result waits).
  mm4f_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
`default_nettype wire
